// ----- rtl/framebuffer_row_write_and_copy_rect_core_assert.svh -----
// Assertion macros shared by the frame store copy engine.
`ifndef FRAMEBUFFER_ROW_WRITE_AND_COPY_RECT_CORE_ASSERT_SVH
`define FRAMEBUFFER_ROW_WRITE_AND_COPY_RECT_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk and masked during reset.
`define FBRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and masked during reset.
`define FBRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fbrc_pkg.sv -----
// Shared types and codes of the frame store copy engine.
package fbrc_pkg;

  // Operation codes of the input channel
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_COPY  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Result kinds of the output channel
  localparam logic [2:0] RES_DROP   = 3'd0;
  localparam logic [2:0] RES_PIXEL  = 3'd1;
  localparam logic [2:0] RES_REGION = 3'd2;
  localparam logic [2:0] RES_READ   = 3'd3;
  localparam logic [2:0] RES_CLEAR  = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_HEIGHT = 1'd1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_DATA_W-1:0] PANEL_RESET = 11'd1024;

  // Dimension width able to hold the largest supported panel size (4096)
  localparam int DIM_W = 13;

  // Clipped copy geometry handed from the clip unit to the sequencer
  typedef struct packed {
    logic             drop;
    logic             down;   // rows top to bottom
    logic             lr;     // columns left to right
    logic [DIM_W-1:0] cw;     // clipped copy width
    logic [DIM_W-1:0] rows;   // rows actually moved
    logic [DIM_W-1:0] hrep;   // reported destination height
  } clip_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SETUP,
    ST_PREP,
    ST_COPY,
    ST_DRAIN,
    ST_CLEAR
  } state_t;

endpackage

// ----- rtl/fbrc_in_if.sv -----
// Input channel: operation transaction with valid/ready handshake.
interface fbrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] dest_x;
  logic [15:0] dest_y;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [15:0] source_x;
  logic [15:0] source_y;
  logic [15:0] pixel_in;

  modport source (
    output valid, opcode, dest_x, dest_y, rect_width, rect_height,
           source_x, source_y, pixel_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, dest_x, dest_y, rect_width, rect_height,
           source_x, source_y, pixel_in,
    output ready
  );
endinterface

// ----- rtl/fbrc_out_if.sv -----
// Result channel: result transaction with valid/ready handshake.
interface fbrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  logic [10:0] out_width;
  logic [10:0] out_height;
  logic [15:0] pixel_out;

  modport source (
    output valid, result_kind, out_x, out_y, out_width, out_height, pixel_out,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_x, out_y, out_width, out_height, pixel_out,
    output ready
  );
endinterface

// ----- rtl/fbrc_clip.sv -----
// Copy rectangle visibility check and clipping against the panel size.
module fbrc_clip (
  input  logic [15:0]                dest_x,
  input  logic [15:0]                dest_y,
  input  logic [15:0]                rect_width,
  input  logic [15:0]                rect_height,
  input  logic [15:0]                source_x,
  input  logic [15:0]                source_y,
  input  logic [fbrc_pkg::DIM_W-1:0] pw,
  input  logic [fbrc_pkg::DIM_W-1:0] ph,
  output fbrc_pkg::clip_t            clip
);
  import fbrc_pkg::*;

  logic [15:0] pw16;
  logic [15:0] ph16;
  logic        vis;
  logic [15:0] room_d;
  logic [15:0] room_s;
  logic [15:0] cw_a;
  logic [15:0] cw_b;
  logic [15:0] top;
  logic [15:0] room_t;
  logic [15:0] room_y;
  logic [15:0] rows;
  logic [15:0] hrep;

  assign pw16 = 16'(pw);
  assign ph16 = 16'(ph);

  // Both corners visible and a nonzero size
  assign vis = (dest_x < pw16) && (dest_y < ph16) && (source_x < pw16) &&
               (source_y < ph16) && (rect_width != 16'd0) && (rect_height != 16'd0);

  // Width clipped by destination and source room
  assign room_d = pw16 - dest_x;
  assign room_s = pw16 - source_x;
  assign cw_a   = (rect_width < room_d) ? rect_width : room_d;
  assign cw_b   = (cw_a < room_s) ? cw_a : room_s;

  // Rows moved stop at the lower of the two rectangles
  assign top    = (dest_y > source_y) ? dest_y : source_y;
  assign room_t = ph16 - top;
  assign rows   = (rect_height < room_t) ? rect_height : room_t;

  // Reported height only looks at the destination
  assign room_y = ph16 - dest_y;
  assign hrep   = (rect_height < room_y) ? rect_height : room_y;

  assign clip.drop = !vis;
  assign clip.down = (dest_y <= source_y);
  assign clip.lr   = (dest_x <= source_x);
  assign clip.cw   = DIM_W'(cw_b);
  assign clip.rows = DIM_W'(rows);
  assign clip.hrep = DIM_W'(hrep);

endmodule

// ----- rtl/framebuffer_row_write_and_copy_rect_core.sv -----
// Top level: RGB565 shadow frame store with pixel write, read, clear and copy.
//
// Usage: operations enter on in_chan (valid/ready); each accepted transaction
// yields exactly one result transaction on out_chan. The user must set panel
// width and height through cfg_we/cfg_index/cfg_wdata only while the block is
// idle; the block does not enforce this. Path from accept to out_chan.valid:
//   write pixel, or any dropped write/read, or clear of an empty panel: straight
//   into the output register; a new write may be accepted every cycle while the
//   receiver takes each result; read pixel: registered store read, then output
//   register; copy rectangle: setup, prep, then one pixel per cycle through the
//   single read and single write port of the store, then drain; a dropped copy:
//   setup, then the output register; clear: one zero write per cycle over the
//   panel width * panel height pixels, then the output register.
// The block works on one operation at a time; the next is accepted once the
// sequencer is idle and the output register is empty or being emptied.
// Reset returns the sequencer to idle, empties the output register and sets
// both panel registers to 1024. The store contents are unknown after reset
// and there is no clearing pass: pixels must be written before being read.
// When the receiver stalls, the result waits in the output register and no
// new operation is accepted until it is taken.
module framebuffer_row_write_and_copy_rect_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  fbrc_in_if.sink                             in_chan,
  fbrc_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [fbrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbrc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fbrc_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int EH    = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

  // Row-major store address with a fixed stride of MAX_WIDTH
  function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] row,
                                             input logic [XW-1:0] col);
    pix_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  endfunction

  // Configuration and effective panel size
  logic [CFG_DATA_W-1:0] disp_w_r;
  logic [CFG_DATA_W-1:0] disp_h_r;
  logic [EW-1:0]         pw_ext;
  logic [EH-1:0]         ph_ext;
  logic [WW-1:0]         pw_eff;
  logic [HW-1:0]         ph_eff;

  // Sequencer
  state_t state_r;
  state_t state_nxt;
  logic   in_acc;
  logic   slot_free;
  logic   pix_ok;
  logic   clr_empty;
  logic   col_last;
  logic   row_last;
  logic   clr_col_last;
  logic   clr_row_last;

  // Latched operation fields
  logic [15:0] dx_r;
  logic [15:0] dy_r;
  logic [15:0] rw_r;
  logic [15:0] rh_r;
  logic [15:0] sx_r;
  logic [15:0] sy_r;

  // Copy geometry and walk pointers
  clip_t         clip;
  logic [WW-1:0] cw_r;
  logic [HW-1:0] rows_r;
  logic [HW-1:0] hrep_r;
  logic          down_r;
  logic          lr_r;
  logic [XW-1:0] src_col_r;
  logic [XW-1:0] dst_col_r;
  logic [XW-1:0] src_col0_r;
  logic [XW-1:0] dst_col0_r;
  logic [YW-1:0] src_row_r;
  logic [YW-1:0] dst_row_r;
  logic [WW-1:0] col_left_r;
  logic [HW-1:0] row_left_r;
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_r;

  // Store ports
  logic [15:0]   store [DEPTH];
  logic [15:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Result register
  logic        res_load;
  logic [2:0]  res_kind;
  logic [9:0]  res_x;
  logic [9:0]  res_y;
  logic [10:0] res_w;
  logic [10:0] res_h;
  logic [15:0] res_pix;
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [9:0]  out_x_r;
  logic [9:0]  out_y_r;
  logic [10:0] out_w_r;
  logic [10:0] out_h_r;
  logic [15:0] out_pix_r;

  // Clamp the panel registers to the store size
  assign pw_ext = EW'(disp_w_r);
  assign ph_ext = EH'(disp_h_r);
  assign pw_eff = (pw_ext > EW'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(pw_ext);
  assign ph_eff = (ph_ext > EH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(ph_ext);

  // Handshake: take a transaction only when idle and the output slot frees up
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && slot_free;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign pix_ok    = (in_chan.dest_x < 16'(pw_eff)) && (in_chan.dest_y < 16'(ph_eff));
  assign clr_empty = (pw_eff == '0) || (ph_eff == '0);

  assign col_last     = (col_left_r == WW'(1));
  assign row_last     = (row_left_r == HW'(1));
  assign clr_col_last = (WW'(dst_col_r) == pw_eff - WW'(1));
  assign clr_row_last = (HW'(dst_row_r) == ph_eff - HW'(1));

  fbrc_clip u_clip (
    .dest_x      (dx_r),
    .dest_y      (dy_r),
    .rect_width  (rw_r),
    .rect_height (rh_r),
    .source_x    (sx_r),
    .source_y    (sy_r),
    .pw          (DIM_W'(pw_eff)),
    .ph          (DIM_W'(ph_eff)),
    .clip        (clip)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.opcode)
            OP_CLEAR: state_nxt = clr_empty ? ST_IDLE : ST_CLEAR;
            OP_WRITE: state_nxt = ST_IDLE;
            OP_COPY:  state_nxt = ST_SETUP;
            OP_READ:  state_nxt = pix_ok ? ST_READ : ST_IDLE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_SETUP: state_nxt = clip.drop ? ST_IDLE : ST_PREP;
      ST_PREP:  state_nxt = ST_COPY;
      ST_COPY:  state_nxt = (col_last && row_last) ? ST_DRAIN : ST_COPY;
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_CLEAR: state_nxt = (clr_col_last && clr_row_last) ? ST_IDLE : ST_CLEAR;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Store ports and result formation
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr(in_chan.dest_y[YW-1:0], in_chan.dest_x[XW-1:0]);
    mem_wdata = in_chan.pixel_in;
    mem_raddr = pix_addr(in_chan.dest_y[YW-1:0], in_chan.dest_x[XW-1:0]);
    res_load  = 1'b0;
    res_kind  = RES_DROP;
    res_x     = '0;
    res_y     = '0;
    res_w     = '0;
    res_h     = '0;
    res_pix   = '0;

    // Write port: pending copy write, clear sweep, or a pixel write
    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = rd_data_r;
    end else if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = pix_addr(dst_row_r, dst_col_r);
      mem_wdata = '0;
    end else if (in_acc && (in_chan.opcode == OP_WRITE) && pix_ok) begin
      mem_we = 1'b1;
    end

    if (state_r == ST_COPY) begin
      mem_raddr = pix_addr(src_row_r, src_col_r);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.opcode)
            OP_CLEAR: begin
              res_load = clr_empty;
              res_kind = RES_CLEAR;
            end
            OP_WRITE: begin
              res_load = 1'b1;
              if (pix_ok) begin
                res_kind = RES_PIXEL;
                res_x    = in_chan.dest_x[9:0];
                res_y    = in_chan.dest_y[9:0];
                res_w    = 11'd1;
                res_h    = 11'd1;
                res_pix  = in_chan.pixel_in;
              end
            end
            OP_READ: begin
              res_load = !pix_ok;
            end
            default: begin
              res_load = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load = 1'b1;
        res_kind = RES_READ;
        res_x    = dx_r[9:0];
        res_y    = dy_r[9:0];
        res_pix  = rd_data_r;
      end
      ST_SETUP: begin
        res_load = clip.drop;
      end
      ST_DRAIN: begin
        res_load = 1'b1;
        res_kind = RES_REGION;
        res_x    = dx_r[9:0];
        res_y    = dy_r[9:0];
        res_w    = 11'(cw_r);
        res_h    = 11'(hrep_r);
      end
      ST_CLEAR: begin
        res_load = clr_col_last && clr_row_last;
        res_kind = RES_CLEAR;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Frame store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= store[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      disp_w_r    <= PANEL_RESET;
      disp_h_r    <= PANEL_RESET;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= (state_r == ST_COPY);
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISP_WIDTH:  disp_w_r <= cfg_wdata;
          CFG_DISP_HEIGHT: disp_h_r <= cfg_wdata;
          default: begin
            disp_w_r <= disp_w_r;
          end
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_kind_r <= res_kind;
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_w_r    <= res_w;
      out_h_r    <= res_h;
      out_pix_r  <= res_pix;
    end
  end

  // Operation fields, copy geometry and walk pointers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dx_r      <= in_chan.dest_x;
          dy_r      <= in_chan.dest_y;
          rw_r      <= in_chan.rect_width;
          rh_r      <= in_chan.rect_height;
          sx_r      <= in_chan.source_x;
          sy_r      <= in_chan.source_y;
          dst_col_r <= '0;
          dst_row_r <= '0;
        end
      end
      ST_SETUP: begin
        cw_r   <= WW'(clip.cw);
        rows_r <= HW'(clip.rows);
        hrep_r <= HW'(clip.hrep);
        down_r <= clip.down;
        lr_r   <= clip.lr;
      end
      ST_PREP: begin
        // Start at the corner that keeps overlapping moves safe
        src_col_r  <= XW'(sx_r + (lr_r ? 16'd0 : 16'(cw_r) - 16'd1));
        dst_col_r  <= XW'(dx_r + (lr_r ? 16'd0 : 16'(cw_r) - 16'd1));
        src_col0_r <= XW'(sx_r + (lr_r ? 16'd0 : 16'(cw_r) - 16'd1));
        dst_col0_r <= XW'(dx_r + (lr_r ? 16'd0 : 16'(cw_r) - 16'd1));
        src_row_r  <= YW'(sy_r + (down_r ? 16'd0 : 16'(rows_r) - 16'd1));
        dst_row_r  <= YW'(dy_r + (down_r ? 16'd0 : 16'(rows_r) - 16'd1));
        col_left_r <= cw_r;
        row_left_r <= rows_r;
      end
      ST_COPY: begin
        // Read one source pixel; its write follows next cycle
        wr_addr_r <= pix_addr(dst_row_r, dst_col_r);
        if (!col_last) begin
          src_col_r  <= lr_r ? src_col_r + XW'(1) : src_col_r - XW'(1);
          dst_col_r  <= lr_r ? dst_col_r + XW'(1) : dst_col_r - XW'(1);
          col_left_r <= col_left_r - WW'(1);
        end else if (!row_last) begin
          src_col_r  <= src_col0_r;
          dst_col_r  <= dst_col0_r;
          src_row_r  <= down_r ? src_row_r + YW'(1) : src_row_r - YW'(1);
          dst_row_r  <= down_r ? dst_row_r + YW'(1) : dst_row_r - YW'(1);
          col_left_r <= cw_r;
          row_left_r <= row_left_r - HW'(1);
        end
      end
      ST_CLEAR: begin
        // Sweep the visible area in raster order
        if (clr_col_last) begin
          dst_col_r <= '0;
          dst_row_r <= dst_row_r + YW'(1);
        end else begin
          dst_col_r <= dst_col_r + XW'(1);
        end
      end
      default: begin
        dx_r <= dx_r;
      end
    endcase
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.out_x       = out_x_r;
  assign out_chan.out_y       = out_y_r;
  assign out_chan.out_width   = out_w_r;
  assign out_chan.out_height  = out_h_r;
  assign out_chan.pixel_out   = out_pix_r;

  `include "framebuffer_row_write_and_copy_rect_core_assert.svh"

  `FBRC_ASSERT_NXT(a_write_result, in_acc && (in_chan.opcode == OP_WRITE), out_valid_r, "write pixel produced no result")
  `FBRC_ASSERT_NXT(a_read_result, state_r == ST_READ, out_valid_r && (out_kind_r == RES_READ), "read data not presented")
  `FBRC_ASSERT_IMP(a_pend_in_copy, wr_pend_r, (state_r == ST_COPY) || (state_r == ST_DRAIN), "copy write outside copy walk")
  `FBRC_ASSERT_IMP(a_copy_counts, state_r == ST_COPY, (col_left_r != '0) && (row_left_r != '0), "copy counter ran out")

endmodule

// ----- bench/fbrc_result_checker.sv -----
// Result checker for the frame store copy engine: predicts and compares every result.
module fbrc_result_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fbrc_in_if                              ops,
  fbrc_out_if                             results,
  input  logic                            cfg_we,
  input  logic [fbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);
  import fbrc_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [10:0] w;
    logic [10:0] h;
    logic [15:0] pix;
  } result_t;

  // Shadow copy of the frame store and the panel registers
  bit [15:0]       shadow [MAX_WIDTH*MAX_HEIGHT];
  logic [10:0]     width_reg;
  logic [10:0]     height_reg;
  result_t         awaited_results [$];
  int              mismatches = 0;

  // Print one line per mismatch and count every one
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input logic [2:0] kind);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h (kind %0d)", name, got, want, kind));
  endtask

  // Apply one operation to the shadow store and return the result it causes
  function automatic result_t apply_operation(
    input logic [1:0] op, input logic [15:0] dx, input logic [15:0] dy,
    input logic [15:0] rw, input logic [15:0] rh, input logic [15:0] sx,
    input logic [15:0] sy, input logic [15:0] pix);
    result_t   res;
    int        pw, ph, cw, rows, top_row, r, i, c;
    int        dxi, dyi, sxi, syi, rwi, rhi;
    bit        down;
    bit [15:0] line [MAX_WIDTH];
    res  = '0;
    pw   = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    ph   = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    dxi  = int'(dx);
    dyi  = int'(dy);
    sxi  = int'(sx);
    syi  = int'(sy);
    rwi  = int'(rw);
    rhi  = int'(rh);
    case (op)
      OP_CLEAR: begin
        for (r = 0; r < ph; r++)
          for (c = 0; c < pw; c++) shadow[r*MAX_WIDTH + c] = '0;
        res.kind = RES_CLEAR;
      end
      OP_WRITE: begin
        if (dxi < pw && dyi < ph) begin
          shadow[dyi*MAX_WIDTH + dxi] = pix;
          res.kind = RES_PIXEL;
          res.x    = dx[9:0];
          res.y    = dy[9:0];
          res.w    = 11'd1;
          res.h    = 11'd1;
          res.pix  = pix;
        end
      end
      OP_READ: begin
        if (dxi < pw && dyi < ph) begin
          res.kind = RES_READ;
          res.x    = dx[9:0];
          res.y    = dy[9:0];
          res.pix  = shadow[dyi*MAX_WIDTH + dxi];
        end
      end
      default: begin
        if (dxi < pw && dyi < ph && sxi < pw && syi < ph && rwi != 0 && rhi != 0) begin
          cw      = rwi;
          if (pw - dxi < cw) cw = pw - dxi;
          if (pw - sxi < cw) cw = pw - sxi;
          top_row = (dyi > syi) ? dyi : syi;
          rows    = (rhi < ph - top_row) ? rhi : ph - top_row;
          down    = (dyi <= syi);
          // Move each row as if read whole first; row order keeps overlap safe
          for (i = 0; i < rows; i++) begin
            r = down ? i : rows - 1 - i;
            for (c = 0; c < cw; c++) line[c] = shadow[(syi + r)*MAX_WIDTH + sxi + c];
            for (c = 0; c < cw; c++) shadow[(dyi + r)*MAX_WIDTH + dxi + c] = line[c];
          end
          res.kind = RES_REGION;
          res.x    = dx[9:0];
          res.y    = dy[9:0];
          res.w    = 11'(cw);
          res.h    = 11'((rhi < ph - dyi) ? rhi : ph - dyi);
        end
      end
    endcase
    return res;
  endfunction

  // Track registers, queue predictions on accepted operations, compare results
  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    if (!rst_n) begin
      width_reg  = PANEL_RESET;
      height_reg = PANEL_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DISP_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == CFG_DISP_HEIGHT) height_reg = cfg_wdata;
      end
      if (ops.valid && ops.ready)
        awaited_results.push_back(apply_operation(ops.opcode, ops.dest_x, ops.dest_y,
          ops.rect_width, ops.rect_height, ops.source_x, ops.source_y, ops.pixel_in));
      if (results.valid && results.ready) begin
        seen.kind = results.result_kind;
        seen.x    = results.out_x;
        seen.y    = results.out_y;
        seen.w    = results.out_width;
        seen.h    = results.out_height;
        seen.pix  = results.pixel_out;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with no operation outstanding",
                                    seen.kind));
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", seen.kind, want.kind, want.kind);
          check_field("out_x", seen.x, want.x, want.kind);
          check_field("out_y", seen.y, want.y, want.kind);
          check_field("out_width", seen.w, want.w, want.kind);
          check_field("out_height", seen.h, want.h, want.kind);
          check_field("pixel_out", seen.pix, want.pix, want.kind);
        end
      end
    end
    outstanding <= awaited_results.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- bench/framebuffer_row_write_and_copy_rect_core_tb.sv -----
// Testbench top for the frame store copy engine: stimulus, idling and verdict.
module framebuffer_row_write_and_copy_rect_core_tb;
  import fbrc_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    outstanding;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int idle_mode  = 0;
  int pan_w      = 1024;
  int pan_h      = 1024;
  int ops_sent   = 0;
  int settings   = 1;
  int cycle_count = 0;
  int op_count [4] = '{0, 0, 0, 0};

  fbrc_in_if  op_chan();
  fbrc_out_if res_chan();

  framebuffer_row_write_and_copy_rect_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (op_chan),
    .out_chan  (res_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fbrc_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .ops         (op_chan),
    .results     (res_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    res_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Give up after a generous number of cycles
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, outstanding);
    $display("FAIL");
    $finish;
  end

  // Offer one operation, idling first at random, and hold it until accepted
  task automatic send_op(input logic [1:0] op, input logic [15:0] dx, input logic [15:0] dy,
                         input logic [15:0] rw, input logic [15:0] rh, input logic [15:0] sx,
                         input logic [15:0] sy, input logic [15:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      op_chan.valid <= 1'b0;
      @(posedge clk);
    end
    op_chan.valid       <= 1'b1;
    op_chan.opcode      <= op;
    op_chan.dest_x      <= dx;
    op_chan.dest_y      <= dy;
    op_chan.rect_width  <= rw;
    op_chan.rect_height <= rh;
    op_chan.source_x    <= sx;
    op_chan.source_y    <= sy;
    op_chan.pixel_in    <= pix;
    @(posedge clk);
    while (!op_chan.ready) @(posedge clk);
    ops_sent++;
    op_count[op]++;
  endtask

  // Operation helpers; fields the operation ignores carry random values
  task automatic do_clear();
    send_op(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic do_write(input logic [15:0] x, input logic [15:0] y, input logic [15:0] pix);
    send_op(OP_WRITE, x, y, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), pix);
  endtask

  task automatic do_read(input logic [15:0] x, input logic [15:0] y);
    send_op(OP_READ, x, y, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom));
  endtask

  task automatic do_copy(input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] dx,
                         input logic [15:0] dy, input logic [15:0] w, input logic [15:0] h);
    send_op(OP_COPY, dx, dy, w, h, sx, sy, 16'($urandom));
  endtask

  // Wait until every result has been taken and the block has settled
  task automatic drain_results();
    op_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both panel registers while idle, then move to the next idling mode
  task automatic begin_phase(input int w, input int h);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DISP_WIDTH;
    cfg_wdata <= 11'(w);
    @(posedge clk);
    cfg_index <= CFG_DISP_HEIGHT;
    cfg_wdata <= 11'(h);
    @(posedge clk);
    cfg_we    <= 1'b0;
    pan_w     = (w > 1024) ? 1024 : w;
    pan_h     = (h > 1024) ? 1024 : h;
    settings++;
    idle_mode = (idle_mode + 1) % 4;
    case (idle_mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 52; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 52; end
      default: begin idle_pct = 31; stall_pct <= 31; end
    endcase
  endtask

  // Coordinate inside the panel, or anything when the panel is empty
  function automatic logic [15:0] pick_in(input int n);
    if (n == 0) return 16'($urandom);
    return 16'($urandom_range(n - 1, 0));
  endfunction

  // Copy size: mostly within the panel, sometimes zero, full or huge
  function automatic logic [15:0] pick_span(input int n);
    int r;
    r = $urandom_range(15);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom);
    if (r < 4) return 16'(n);
    return 16'($urandom_range((n > 0) ? n : 1, 1));
  endfunction

  // Mostly well-formed operations inside the panel, with noise and near misses
  task automatic run_random(input int count);
    int n, sel, side;
    logic [15:0] x, y, sx, sy;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        send_op(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (sel < 35) begin
        do_write(pick_in(pan_w), pick_in(pan_h), 16'($urandom));
      end else if (sel < 57) begin
        do_read(pick_in(pan_w), pick_in(pan_h));
      end else if (sel < 89) begin
        do_copy(pick_in(pan_w), pick_in(pan_h), pick_in(pan_w), pick_in(pan_h),
                pick_span(pan_w), pick_span(pan_h));
      end else if (sel < 92) begin
        do_clear();
      end else begin
        // Push one coordinate just past the panel edge
        x    = pick_in(pan_w);
        y    = pick_in(pan_h);
        sx   = pick_in(pan_w);
        sy   = pick_in(pan_h);
        side = $urandom_range(3);
        case (side)
          0: x  = 16'(pan_w + $urandom_range(2));
          1: y  = 16'(pan_h + $urandom_range(2));
          2: sx = 16'(pan_w + $urandom_range(2));
          default: sy = 16'(pan_h + $urandom_range(2));
        endcase
        sel = $urandom_range(2);
        if (sel == 0) do_write(x, y, 16'($urandom));
        else if (sel == 1) do_read(x, y);
        else do_copy(sx, sy, x, y, pick_span(pan_w), pick_span(pan_h));
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_DISP_WIDTH;
    cfg_wdata           <= '0;
    op_chan.valid       <= 1'b0;
    op_chan.opcode      <= OP_CLEAR;
    op_chan.dest_x      <= '0;
    op_chan.dest_y      <= '0;
    op_chan.rect_width  <= '0;
    op_chan.rect_height <= '0;
    op_chan.source_x    <= '0;
    op_chan.source_y    <= '0;
    op_chan.pixel_in    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full panel after reset: touch only pixels written here
    do_write(16'd0, 16'd0, 16'hFFFF);
    do_write(16'd1023, 16'd1023, 16'h5AA5);
    do_write(16'd1022, 16'd1023, 16'hA55A);
    do_write(16'd1024, 16'd0, 16'h1234);
    do_write(16'hFFFF, 16'hFFFF, 16'hFFFF);
    do_read(16'd0, 16'd0);
    do_read(16'd0, 16'd1024);
    // Huge size clipped to the two source pixels on the bottom row
    do_copy(16'd1022, 16'd1023, 16'd0, 16'd1023, 16'hFFFF, 16'hFFFF);
    // Overlapping shift to the right within one row
    do_copy(16'd0, 16'd1023, 16'd1, 16'd1023, 16'd2, 16'd1);
    do_read(16'd2, 16'd1023);
    // Source rows run off the panel: one row moves, seven are reported
    do_copy(16'd1022, 16'd1023, 16'd5, 16'd0, 16'd2, 16'd7);
    do_read(16'd6, 16'd0);
    do_copy(16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd4);
    do_copy(16'd0, 16'd1024, 16'd1, 16'd1, 16'd4, 16'd4);

    // Small panel: copy direction and clipping
    begin_phase(8, 8);
    do_clear();
    do_write(16'd7, 16'd7, 16'h1234);
    do_copy(16'd0, 16'd0, 16'd1, 16'd1, 16'd4, 16'd4);
    do_copy(16'd2, 16'd2, 16'd0, 16'd0, 16'd100, 16'd100);
    do_copy(16'd0, 16'd0, 16'd0, 16'd6, 16'd8, 16'd4);
    do_read(16'd7, 16'd7);

    // Empty panel: everything but clear drops
    begin_phase(0, 5);
    do_clear();
    do_write(16'd0, 16'd0, 16'h00FF);
    do_copy(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
    do_read(16'd0, 16'd0);
    begin_phase(5, 0);
    do_clear();
    do_write(16'd0, 16'd0, 16'h00FF);

    // Extreme panel shapes, including clamped registers
    begin_phase(1024, 1);
    do_clear();
    run_random(30);
    begin_phase(1, 1024);
    do_clear();
    run_random(30);
    begin_phase(2047, 2);
    do_clear();
    run_random(30);
    begin_phase(3, 2047);
    do_clear();
    run_random(30);

    // Random panels of modest size
    while (ops_sent < 900) begin
      begin_phase($urandom_range(48, 1), $urandom_range(24, 1));
      do_clear();
      run_random(50);
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Ran %0d operations over %0d panel settings in %0d cycles",
             ops_sent, settings, cycle_count);
    $display("  clear %0d, write %0d, copy %0d, read %0d; mismatches %0d",
             op_count[OP_CLEAR], op_count[OP_WRITE], op_count[OP_COPY], op_count[OP_READ],
             fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- framebuffer_row_write_and_copy_rect_core.f -----
+incdir+rtl
rtl/fbrc_pkg.sv
rtl/fbrc_in_if.sv
rtl/fbrc_out_if.sv
rtl/fbrc_clip.sv
rtl/framebuffer_row_write_and_copy_rect_core.sv
bench/fbrc_result_checker.sv
bench/framebuffer_row_write_and_copy_rect_core_tb.sv
